@@ design/rphc_pkg.sv @@
// Package for the relay packet header checker: header layout offsets,
// register indexes, fault codes and the decoded header field struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rphc_pkg;

  localparam int IdBytes   = 32;
  localparam int HashBytes = 32;

  localparam int OffVer   = 0;
  localparam int OffKind  = 2;
  localparam int OffHlen  = 4;
  localparam int OffSrc   = 8;
  localparam int OffTgt   = OffSrc + IdBytes;
  localparam int OffAdm   = OffTgt + IdBytes;
  localparam int OffTok   = OffAdm + HashBytes;
  localparam int OffRoute = OffTok + HashBytes;
  localparam int OffSeq   = OffRoute + HashBytes;
  localparam int OffCpb   = OffSeq + 8;
  localparam int OffMaxc  = OffCpb + 8;
  localparam int OffPlen  = OffMaxc + 8;
  localparam int OffRsv   = OffPlen + 4;
  localparam int OffPhash = OffRsv + 4;
  localparam int HdrLen   = OffPhash + HashBytes;

  localparam int PosW = 33;
  localparam logic [PosW-1:0] PosMax = '1;

  localparam int NumIds = 6;
  localparam logic [NumIds-1:0] AllIdsSeen = '1;

  localparam int OutDataW = 232;

  localparam logic CfgVersion = 1'b0;
  localparam logic CfgKind    = 1'b1;

  typedef enum logic [3:0] {
    FAULT_NONE     = 4'd0,
    FAULT_SHORT    = 4'd1,
    FAULT_VERSION  = 4'd2,
    FAULT_KIND     = 4'd3,
    FAULT_HDR_LEN  = 4'd4,
    FAULT_LENGTH   = 4'd5,
    FAULT_RESERVED = 4'd6,
    FAULT_ZERO_ID  = 4'd7,
    FAULT_COST     = 4'd8
  } fault_e;

  typedef struct packed {
    logic [PosW-1:0]   pos;
    logic [15:0]       version;
    logic [15:0]       kind;
    logic [31:0]       hdr_len;
    logic [NumIds-1:0] id_seen;
    logic [63:0]       seq;
    logic [63:0]       cpb;
    logic [63:0]       maxc;
    logic [31:0]       plen;
    logic [31:0]       rsv;
  } fields_t;

endpackage
`default_nettype wire

@@ design/rphc_field_capture.sv @@
// Per-packet header state: saturating byte position, little-endian field
// lanes and nonzero flags of the identifier and hash fields.
// Depends on rphc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rphc_field_capture (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire logic           last_i,
  input  wire logic [7:0]     byte_i,
  output rphc_pkg::fields_t   fields_d_o,
  output rphc_pkg::fields_t   fields_q_o
);
  import rphc_pkg::*;

  fields_t fields_q, fields_d, upd;

  function automatic logic in_range(logic [PosW-1:0] pos, int off, int len);
    return (pos >= PosW'(off)) && (pos < PosW'(off + len));
  endfunction

  always_comb begin
    upd = fields_q;
    for (int k = 0; k < 2; k++) begin
      if (fields_q.pos == PosW'(OffVer + k)) upd.version[8*k +: 8] = byte_i;
      if (fields_q.pos == PosW'(OffKind + k)) upd.kind[8*k +: 8] = byte_i;
    end
    for (int k = 0; k < 4; k++) begin
      if (fields_q.pos == PosW'(OffHlen + k)) upd.hdr_len[8*k +: 8] = byte_i;
      if (fields_q.pos == PosW'(OffPlen + k)) upd.plen[8*k +: 8] = byte_i;
      if (fields_q.pos == PosW'(OffRsv + k)) upd.rsv[8*k +: 8] = byte_i;
    end
    for (int k = 0; k < 8; k++) begin
      if (fields_q.pos == PosW'(OffSeq + k)) upd.seq[8*k +: 8] = byte_i;
      if (fields_q.pos == PosW'(OffCpb + k)) upd.cpb[8*k +: 8] = byte_i;
      if (fields_q.pos == PosW'(OffMaxc + k)) upd.maxc[8*k +: 8] = byte_i;
    end
    if (byte_i != 8'd0) begin
      if (in_range(fields_q.pos, OffSrc, IdBytes)) upd.id_seen[0] = 1'b1;
      if (in_range(fields_q.pos, OffTgt, IdBytes)) upd.id_seen[1] = 1'b1;
      if (in_range(fields_q.pos, OffAdm, HashBytes)) upd.id_seen[2] = 1'b1;
      if (in_range(fields_q.pos, OffTok, HashBytes)) upd.id_seen[3] = 1'b1;
      if (in_range(fields_q.pos, OffRoute, HashBytes)) upd.id_seen[4] = 1'b1;
      if (in_range(fields_q.pos, OffPhash, HashBytes)) upd.id_seen[5] = 1'b1;
    end
    if (fields_q.pos != PosMax) upd.pos = fields_q.pos + PosW'(1);

    fields_d = fields_q;
    if (step_i) begin
      fields_d = last_i ? '0 : upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fields_q <= '0;
    end else begin
      fields_q <= fields_d;
    end
  end

  assign fields_d_o = upd;
  assign fields_q_o = fields_q;

endmodule
`default_nettype wire

@@ design/rphc_cost_unit.sv @@
// Cost check pipeline: payload length times cost per byte as two 32x32
// partial products, then nonzero and overflow tests and compare against the cost limit.
// Depends on rphc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rphc_cost_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] plen_i,
  input  wire logic [63:0] cpb_i,
  input  wire logic [63:0] maxc_i,
  output logic             cost_ok_o
);
  import rphc_pkg::*;

  logic [63:0] prod_lo_q, prod_hi_q;
  logic        nonzero_q;
  logic        cost_ok_q, cost_ok_d;
  logic [95:0] total;

  always_ff @(posedge clk_i) begin
    prod_lo_q <= plen_i * cpb_i[31:0];
    prod_hi_q <= plen_i * cpb_i[63:32];
  end

  assign total = {32'd0, prod_lo_q} + {prod_hi_q, 32'd0};
  assign cost_ok_d = nonzero_q && (total[95:64] == 32'd0) && (total[63:0] <= maxc_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonzero_q <= 1'b0;
      cost_ok_q <= 1'b0;
    end else begin
      nonzero_q <= (plen_i != 32'd0) && (cpb_i != 64'd0) && (maxc_i != 64'd0);
      cost_ok_q <= cost_ok_d;
    end
  end

  assign cost_ok_o = cost_ok_q;

endmodule
`default_nettype wire

@@ design/relay_packet_header_checker_unit.sv @@
// Top level of the relay packet header checker: input register, field
// capture, cost pipeline, verdict logic and result register.
// Depends on rphc_pkg, rphc_field_capture and rphc_cost_unit.
//
// Bytes of a packet enter on the s_axis channel, one item per byte, with
// s_axis_tlast_i on the final byte. Every item is taken at one per cycle,
// save for a final byte held back by m_axis as told below. Only the final
// byte produces a result item on m_axis: the verdict, the fault code and
// the decoded sequence, payload length and cost fields. A final byte is
// first held in the input register; once the result register is free or
// being read, its verdict is loaded there and offered on m_axis. Each
// byte takes a single pass from input to result register; the cost
// product runs in its own two-stage pipeline during the trailing header
// bytes. When m_axis stalls with a result held, non-final bytes still flow;
// a further final byte waits in the input register and s_axis_tready_o
// drops. Reset clears the packet state, empties both registers and sets
// expected version and kind to one. cfg writes take effect on the next
// clock edge.
`timescale 1ns / 1ps
`default_nettype none
module relay_packet_header_checker_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] byte_value
  input  wire logic        s_axis_tlast_i,   // last_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [0] packet_ok, [4:1] fault_code, [68:5] sequence_number,
  // [100:69] payload_length, [164:101] cost_per_byte_out,
  // [228:165] cost_limit_out, [231:229] zero
  output logic [rphc_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import rphc_pkg::*;

  logic [15:0] exp_version_q, exp_kind_q;
  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic        out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q;
  logic        out_free, advance, emit;
  fields_t     fields_d, fields_q;
  logic        cost_ok;
  fault_e      fault;
  logic [PosW-1:0] need_len;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign advance  = in_valid_q && (!last_q || out_free);
  assign emit     = advance && last_q;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_version_q <= 16'd1;
      exp_kind_q    <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgVersion: exp_version_q <= cfg_data_i;
        CfgKind:    exp_kind_q    <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      byte_q <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
    end
  end

  rphc_field_capture u_capture (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .last_i     (last_q),
    .byte_i     (byte_q),
    .fields_d_o (fields_d),
    .fields_q_o (fields_q)
  );

  rphc_cost_unit u_cost (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .plen_i    (fields_q.plen),
    .cpb_i     (fields_q.cpb),
    .maxc_i    (fields_q.maxc),
    .cost_ok_o (cost_ok)
  );

  assign need_len = PosW'(HdrLen) + {1'b0, fields_d.plen};

  always_comb begin
    if (fields_d.pos < PosW'(HdrLen)) begin
      fault = FAULT_SHORT;
    end else if (fields_d.version != exp_version_q) begin
      fault = FAULT_VERSION;
    end else if (fields_d.kind != exp_kind_q) begin
      fault = FAULT_KIND;
    end else if (fields_d.hdr_len != 32'(HdrLen)) begin
      fault = FAULT_HDR_LEN;
    end else if (need_len[PosW-1] || (fields_d.pos != need_len)) begin
      fault = FAULT_LENGTH;
    end else if (fields_d.rsv != 32'd0) begin
      fault = FAULT_RESERVED;
    end else if (fields_d.id_seen != AllIdsSeen) begin
      fault = FAULT_ZERO_ID;
    end else if (!cost_ok) begin
      fault = FAULT_COST;
    end else begin
      fault = FAULT_NONE;
    end
  end

  assign out_valid_d = (out_valid_q && !m_axis_tready_i) || emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= {3'd0, fields_d.maxc, fields_d.cpb, fields_d.plen, fields_d.seq,
                     fault, (fault == FAULT_NONE)};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
`default_nettype wire

@@ tb/sv/tb_relay_packet_header_checker_unit.sv @@
// Testbench for relay_packet_header_checker_unit: byte stream driver, result monitor
// and a byte-level predictor of the verdict and decoded header fields.
// Depends on rphc_pkg and the relay_packet_header_checker_unit RTL.
`timescale 1ns / 1ps
module tb_relay_packet_header_checker_unit;
  import rphc_pkg::*;

  localparam int unsigned CycleLimit  = 3000000;
  localparam int unsigned ParkCycles  = 400;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomItems = 1950;

  typedef struct packed {
    logic [7:0] value;
    logic       tail;
  } src_item_t;

  typedef struct packed {
    logic [63:0] cost_limit;
    logic [63:0] unit_cost;
    logic [31:0] length_word;
    logic [63:0] seq_num;
    logic [3:0]  fault;
    logic        ok;
  } verdict_t;

  typedef struct packed {
    logic [15:0]       ver;
    logic [15:0]       kind;
    logic [31:0]       hlen;
    logic [NumIds-1:0] blank_ids;
    logic [63:0]       seq;
    logic [63:0]       cpb;
    logic [63:0]       maxc;
    logic [31:0]       plen;
    logic [31:0]       rsv;
  } relay_hdr_t;

  typedef enum int {
    PK_GOOD, PK_NOISE, PK_TRUNC, PK_BAD_VER, PK_BAD_KIND, PK_BAD_HLEN, PK_BAD_LEN,
    PK_WRAP, PK_RSV, PK_ZERO_ID, PK_NO_PLEN, PK_NO_CPB, PK_NO_MAXC, PK_OVER,
    PK_OVERFLOW, PK_EXACT
  } pkt_kind_e;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we     = 1'b0;
  logic                cfg_idx    = CfgVersion;
  logic [15:0]         cfg_data   = '0;
  logic                s_valid    = 1'b0;
  logic                s_ready;
  logic [7:0]          s_data     = '0;
  logic                s_last     = 1'b0;
  logic                m_valid;
  logic                m_ready    = 1'b0;
  logic [OutDataW-1:0] m_data;

  logic                park_req   = 1'b0;
  int unsigned         park_left  = 0;
  int unsigned         src_gap    = 0;
  int unsigned         snk_gap    = 0;
  bit                  src_calm   = 1'b0;
  bit                  snk_calm   = 1'b0;
  int unsigned         cycle_count = 0;
  int unsigned         items_queued = 0;
  int unsigned         mismatches = 0;

  logic [15:0]         want_version = 16'h0001;
  logic [15:0]         want_kind    = 16'h0001;
  fields_t             pkt = '0;

  src_item_t           byte_q [$];
  verdict_t            verdict_q [$];

  relay_packet_header_checker_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic int unsigned id_base(int unsigned i);
    case (i)
      0: return OffSrc;
      1: return OffTgt;
      2: return OffAdm;
      3: return OffTok;
      4: return OffRoute;
      default: return OffPhash;
    endcase
  endfunction

  // Advance the packet state by one byte; on the final byte form the verdict and clear.
  task automatic take_byte(input logic [7:0] b, input logic tail, output bit fire,
                           output verdict_t v);
    int unsigned  p;
    logic [63:0]  need;
    logic [127:0] prod;
    fault_e       f;
    fire = 1'b0;
    v    = '0;
    if (pkt.pos < HdrLen) begin
      p = 32'(pkt.pos);
      if (p >= OffVer && p < OffVer + 2)   pkt.version[8*(p-OffVer) +: 8] = b;
      if (p >= OffKind && p < OffKind + 2) pkt.kind[8*(p-OffKind) +: 8] = b;
      if (p >= OffHlen && p < OffHlen + 4) pkt.hdr_len[8*(p-OffHlen) +: 8] = b;
      if (p >= OffSeq && p < OffSeq + 8)   pkt.seq[8*(p-OffSeq) +: 8] = b;
      if (p >= OffCpb && p < OffCpb + 8)   pkt.cpb[8*(p-OffCpb) +: 8] = b;
      if (p >= OffMaxc && p < OffMaxc + 8) pkt.maxc[8*(p-OffMaxc) +: 8] = b;
      if (p >= OffPlen && p < OffPlen + 4) pkt.plen[8*(p-OffPlen) +: 8] = b;
      if (p >= OffRsv && p < OffRsv + 4)   pkt.rsv[8*(p-OffRsv) +: 8] = b;
      for (int i = 0; i < NumIds; i++) begin
        if (p >= id_base(i) && p < id_base(i) + (i < 2 ? IdBytes : HashBytes) && b != 0)
          pkt.id_seen[i] = 1'b1;
      end
    end
    if (pkt.pos != PosMax) pkt.pos = pkt.pos + 1;
    if (!tail) return;

    need = 64'(HdrLen) + 64'(pkt.plen);
    prod = 128'(pkt.plen) * 128'(pkt.cpb);
    if (pkt.pos < HdrLen) f = FAULT_SHORT;
    else if (pkt.version != want_version) f = FAULT_VERSION;
    else if (pkt.kind != want_kind) f = FAULT_KIND;
    else if (pkt.hdr_len != HdrLen) f = FAULT_HDR_LEN;
    else if (need > 64'hFFFF_FFFF || 64'(pkt.pos) != need) f = FAULT_LENGTH;
    else if (pkt.rsv != 0) f = FAULT_RESERVED;
    else if (pkt.id_seen != AllIdsSeen) f = FAULT_ZERO_ID;
    else if (pkt.plen == 0 || pkt.cpb == 0 || pkt.maxc == 0) f = FAULT_COST;
    else if (prod[127:64] != 0 || prod[63:0] > pkt.maxc) f = FAULT_COST;
    else f = FAULT_NONE;

    v.ok          = (f == FAULT_NONE);
    v.fault       = f;
    v.seq_num     = pkt.seq;
    v.length_word = pkt.plen;
    v.unit_cost   = pkt.cpb;
    v.cost_limit  = pkt.maxc;
    pkt  = '0;
    fire = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Serialize a header and random payload; the final byte of total carries tlast.
  task automatic queue_packet(input relay_hdr_t h, input int unsigned total);
    logic [7:0]  hdr [HdrLen];
    int unsigned key;
    int unsigned span;
    bit          sparse;
    src_item_t   it;
    sparse = 1'($urandom_range(0, 1));
    for (int k = 0; k < 2; k++) begin
      hdr[OffVer+k]  = h.ver[8*k +: 8];
      hdr[OffKind+k] = h.kind[8*k +: 8];
    end
    for (int k = 0; k < 4; k++) begin
      hdr[OffHlen+k] = h.hlen[8*k +: 8];
      hdr[OffPlen+k] = h.plen[8*k +: 8];
      hdr[OffRsv+k]  = h.rsv[8*k +: 8];
    end
    for (int k = 0; k < 8; k++) begin
      hdr[OffSeq+k]  = h.seq[8*k +: 8];
      hdr[OffCpb+k]  = h.cpb[8*k +: 8];
      hdr[OffMaxc+k] = h.maxc[8*k +: 8];
    end
    for (int i = 0; i < NumIds; i++) begin
      span = (i < 2) ? IdBytes : HashBytes;
      key  = $urandom_range(0, span - 1);
      for (int k = 0; k < span; k++) begin
        if (h.blank_ids[i]) hdr[id_base(i)+k] = 8'h00;
        else if (k == key) hdr[id_base(i)+k] = 8'($urandom_range(1, 255));
        else if (sparse) hdr[id_base(i)+k] = 8'h00;
        else hdr[id_base(i)+k] = 8'($urandom);
      end
    end
    for (int unsigned p = 0; p < total; p++) begin
      it.value = (p < HdrLen) ? hdr[p] : 8'($urandom);
      it.tail  = (p == total - 1);
      byte_q.push_back(it);
      items_queued++;
    end
  endtask

  function automatic relay_hdr_t good_hdr(logic [31:0] plen);
    relay_hdr_t  h;
    logic [64:0] top;
    h.ver       = want_version;
    h.kind      = want_kind;
    h.hlen      = HdrLen;
    h.blank_ids = '0;
    h.seq       = {$urandom, $urandom};
    h.plen      = plen;
    h.rsv       = '0;
    h.cpb       = {$urandom, $urandom} >> $urandom_range(4, 63);
    if (h.cpb == 0) h.cpb = 64'd1;
    top    = 65'(h.cpb * 64'(plen)) + 65'({$urandom, $urandom} >> $urandom_range(0, 63));
    h.maxc = top[64] ? '1 : top[63:0];
    return h;
  endfunction

  function automatic relay_hdr_t rand_hdr();
    relay_hdr_t h;
    h.ver       = 16'($urandom);
    h.kind      = 16'($urandom);
    h.hlen      = $urandom_range(0, 1) ? 32'(HdrLen) : 32'($urandom);
    h.blank_ids = NumIds'($urandom);
    h.seq       = {$urandom, $urandom};
    h.cpb       = {$urandom, $urandom};
    h.maxc      = {$urandom, $urandom};
    h.plen      = $urandom_range(0, 1) ? 32'($urandom_range(0, 8)) : 32'($urandom);
    h.rsv       = $urandom_range(0, 1) ? 32'd0 : 32'($urandom);
    return h;
  endfunction

  task automatic queue_case(input pkt_kind_e kind);
    relay_hdr_t  h;
    int unsigned total;
    h     = good_hdr(32'($urandom_range(1, 12)));
    total = HdrLen + h.plen;
    case (kind)
      PK_NOISE: begin
        h     = rand_hdr();
        total = ($urandom_range(0, 3) == 0) ? $urandom_range(1, HdrLen + 8)
                                            : $urandom_range(1, 24);
      end
      PK_TRUNC:    total = $urandom_range(1, HdrLen - 1);
      PK_BAD_VER:  h.ver = h.ver ^ 16'($urandom_range(1, 16'hFFFF));
      PK_BAD_KIND: h.kind = h.kind ^ 16'($urandom_range(1, 16'hFFFF));
      PK_BAD_HLEN: begin
        h.hlen = $urandom_range(0, 1) ? 32'($urandom)
                                      : 32'(HdrLen) ^ (32'd1 << $urandom_range(0, 31));
        if (h.hlen == HdrLen) h.hlen = h.hlen + 1;
      end
      PK_BAD_LEN: begin
        if ($urandom_range(0, 1)) total = total + $urandom_range(1, 6);
        else total = total - $urandom_range(1, h.plen);
      end
      PK_WRAP: begin
        h.plen = 32'hFFFF_FFFF - 32'($urandom_range(0, HdrLen - 1));
        total  = HdrLen + $urandom_range(0, 8);
      end
      PK_RSV: begin
        h.rsv = 32'($urandom);
        if (h.rsv == 0) h.rsv = 32'd1 << $urandom_range(0, 31);
      end
      PK_ZERO_ID: h.blank_ids = NumIds'($urandom_range(1, 63));
      PK_NO_PLEN: begin
        h.plen = '0;
        total  = HdrLen;
      end
      PK_NO_CPB:  h.cpb = '0;
      PK_NO_MAXC: h.maxc = '0;
      PK_OVER:    h.maxc = h.cpb * h.plen - 64'd1;
      PK_OVERFLOW: begin
        h.cpb  = {1'b1, 31'($urandom), $urandom};
        h.plen = 32'($urandom_range(2, 12));
        h.maxc = '1;
        total  = HdrLen + h.plen;
      end
      PK_EXACT: h.maxc = h.cpb * h.plen;
      default: ;
    endcase
    queue_packet(h, total);
  endtask

  task automatic program_cfg(input logic [15:0] ver, input logic [15:0] kind);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgVersion;
    cfg_data <= ver;
    want_version = ver;
    @(posedge clk_i);
    cfg_idx  <= CfgKind;
    cfg_data <= kind;
    want_kind = kind;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic await_idle();
    do @(negedge clk_i);
    while (byte_q.size() != 0 || s_valid || verdict_q.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Byte driver: hold each item until taken, then insert a random gap.
  always @(posedge clk_i) begin
    src_item_t it;
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || s_ready) begin
      if (src_gap != 0 || byte_q.size() == 0) begin
        s_valid <= 1'b0;
        if (src_gap != 0) src_gap <= src_gap - 1;
      end else begin
        it = byte_q.pop_front();
        s_data  <= it.value;
        s_last  <= it.tail;
        s_valid <= 1'b1;
        src_gap <= pick_gap(src_calm);
      end
    end
  end

  // Result sink: random stalls plus the long hold-off on request.
  always @(posedge clk_i) begin
    logic        ready_nxt;
    int unsigned g;
    ready_nxt = 1'b0;
    if (park_req) park_left <= ParkCycles;
    else if (park_left != 0) park_left <= park_left - 1;
    if (rst_ni && !park_req && park_left == 0) begin
      if (snk_gap != 0) begin
        snk_gap <= snk_gap - 1;
      end else if (m_ready && m_valid) begin
        g = pick_gap(snk_calm);
        snk_gap  <= g;
        ready_nxt = (g == 0);
      end else begin
        ready_nxt = snk_calm || ($urandom_range(0, 3) != 0);
      end
    end
    m_ready <= ready_nxt;
  end

  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) src_calm <= ~src_calm;
    if ($urandom_range(0, 299) == 0) snk_calm <= ~snk_calm;
  end

  always @(posedge clk_i) begin
    verdict_t got;
    verdict_t want;
    bit       fire;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        got = verdict_t'(m_data[$bits(verdict_t)-1:0]);
        if (verdict_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %0h", $time, got);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          check_field("packet_ok", 64'(want.ok), 64'(got.ok));
          check_field("fault_code", 64'(want.fault), 64'(got.fault));
          check_field("sequence_number", want.seq_num, got.seq_num);
          check_field("length field", 64'(want.length_word), 64'(got.length_word));
          check_field("unit cost", want.unit_cost, got.unit_cost);
          check_field("cost_limit", want.cost_limit, got.cost_limit);
        end
      end
      if (s_valid && s_ready) begin
        take_byte(s_data, s_last, fire, want);
        if (fire) verdict_q.push_back(want);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** relay_packet_header_checker_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    relay_hdr_t  h;
    int unsigned phase_end;
    int unsigned r;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values of the registers: a lone byte, then a passing packet at full scale
    queue_packet(rand_hdr(), 1);
    h      = good_hdr(32'd1);
    h.seq  = '1;
    h.cpb  = '1;
    h.maxc = '1;
    queue_packet(h, HdrLen + 1);
    await_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: program_cfg(16'h0000, 16'h0000);
        1: program_cfg(16'hFFFF, 16'hFFFF);
        2: program_cfg(16'($urandom), 16'($urandom));
        default: program_cfg(16'h0001, 16'hFFFF);
      endcase
      if (ph == 1) begin
        // stall the sink while a burst of tiny packets backs up the input
        @(posedge clk_i);
        park_req <= 1'b1;
        @(posedge clk_i);
        park_req <= 1'b0;
        repeat (16) queue_packet(rand_hdr(), $urandom_range(1, 3));
      end
      phase_end = (ph + 1) * RandomItems / 4;
      while (items_queued < phase_end) begin
        if (phase_end - items_queued < HdrLen) begin
          queue_packet(rand_hdr(), $urandom_range(1, phase_end - items_queued));
        end else begin
          r = $urandom_range(0, 99);
          if (r < 30) queue_case(PK_GOOD);
          else if (r < 45) queue_case(PK_NOISE);
          else if (r < 52) queue_case(PK_TRUNC);
          else queue_case(pkt_kind_e'($urandom_range(PK_BAD_VER, PK_EXACT)));
        end
      end
      await_idle();
    end

    if (mismatches == 0) begin
      $display("** relay_packet_header_checker_unit: PASSED **");
    end else begin
      $display("** relay_packet_header_checker_unit: FAILED **");
    end
    $finish;
  end

endmodule
